/* design/lcgj_pkg.sv */
// Package for the LCG jump-ahead block: widths, generator constants, op codes
// and the structs passed between the sequencer, multiply-add unit and top.
// No dependencies.
package lcgj_pkg;

   localparam int STATE_W   = 31;
   localparam int VALUE_W   = 32;
   localparam int OP_W      = 2;
   localparam int SKIP_BITS = 32;
   // only the bits of value that exist can count towards a jump
   localparam int SKIP_W    = (SKIP_BITS < VALUE_W) ? SKIP_BITS : VALUE_W;

   localparam logic [STATE_W-1:0] LCG_MUL = STATE_W'(1103515245);
   localparam logic [STATE_W-1:0] LCG_ADD = STATE_W'(12345);

   localparam logic [OP_W-1:0] OP_LOAD = OP_W'(0);
   localparam logic [OP_W-1:0] OP_NEXT = OP_W'(1);
   localparam logic [OP_W-1:0] OP_JUMP = OP_W'(2);

   // operands of the shared multiply-add: res = (mul * y + add) mod 2^31
   typedef struct packed {
      logic [STATE_W-1:0] mul;
      logic [STATE_W-1:0] y;
      logic [STATE_W-1:0] add;
   } mac_op_type;

   // sequencer status towards the result register
   typedef struct packed {
      logic               done;
      logic [STATE_W-1:0] state;
   } ctrl_stat_type;

endpackage

/* design/lcgj_if.sv */
// Valid/ready channel interfaces for the LCG jump-ahead block.
// Depends on lcgj_pkg for field widths.
interface lcgj_req_if;
   import lcgj_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface lcgj_rsp_if;
   import lcgj_pkg::*;

   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] rand_value;

   modport source (output valid, output rand_value, input ready);
   modport sink   (input valid, input rand_value, output ready);
endinterface

/* design/lcgj_mac.sv */
// Shared multiply-add unit, mod 2^31: one 31x31 low-half product plus an add.
// Depends on lcgj_pkg; the caller registers the result.
module lcgj_mac (
   input  lcgj_pkg::mac_op_type          op,
   output logic [lcgj_pkg::STATE_W-1:0]  res
);
   import lcgj_pkg::*;

   logic [STATE_W-1:0] prod_lo;

   // only the low 31 bits of the product survive the modulus
   assign prod_lo = STATE_W'(op.mul * op.y);
   assign res     = STATE_W'(prod_lo + op.add);

endmodule

/* design/lcgj_ctrl.sv */
// Sequencer for the LCG: holds the generator state and the affine map
// (pmul, padd) and steps the shared multiply-add through a jump, bit by bit.
// Depends on lcgj_pkg, lcgj_if and lcgj_mac.
module lcgj_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   lcgj_req_if.sink                req_port,
   input  logic                    out_free,
   output lcgj_pkg::ctrl_stat_type stat
);
   import lcgj_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_STEP     = 6'b000010,
      S_JUMP_Y   = 6'b000100,
      S_JUMP_ADD = 6'b001000,
      S_JUMP_MUL = 6'b010000,
      S_DONE     = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [STATE_W-1:0] y_ff, y_in;
   logic [STATE_W-1:0] pmul_ff, pmul_in;
   logic [STATE_W-1:0] padd_ff, padd_in;
   logic [SKIP_W-1:0]  skip_ff, skip_in;
   logic [SKIP_W-1:0]  skip_rest;
   logic [SKIP_W-1:0]  skip_new;
   mac_op_type         mac_op;
   logic [STATE_W-1:0] mac_res;
   logic               accept;

   lcgj_mac u_mac (
      .op  (mac_op),
      .res (mac_res)
   );

   assign req_port.ready = (state_ff == S_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign skip_rest      = skip_ff >> 1;
   assign skip_new       = req_port.value[SKIP_W-1:0];

   always_comb begin
      mac_op = '0;
      unique case (state_ff)
         S_STEP: begin
            mac_op.mul = LCG_MUL;
            mac_op.y   = y_ff;
            mac_op.add = LCG_ADD;
         end
         S_JUMP_Y: begin
            mac_op.mul = pmul_ff;
            mac_op.y   = y_ff;
            mac_op.add = padd_ff;
         end
         S_JUMP_ADD: begin
            // square the map, additive part: k' = m*k + k
            mac_op.mul = pmul_ff;
            mac_op.y   = padd_ff;
            mac_op.add = padd_ff;
         end
         S_JUMP_MUL: begin
            mac_op.mul = pmul_ff;
            mac_op.y   = pmul_ff;
            mac_op.add = '0;
         end
         default: begin
            mac_op = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      y_in     = y_ff;
      pmul_in  = pmul_ff;
      padd_in  = padd_ff;
      skip_in  = skip_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pmul_in = LCG_MUL;
               padd_in = LCG_ADD;
               skip_in = skip_new;
               case (req_port.op)
                  OP_LOAD: begin
                     y_in     = req_port.value[STATE_W-1:0];
                     state_in = S_DONE;
                  end
                  OP_NEXT: state_in = S_STEP;
                  OP_JUMP: state_in = (skip_new == '0) ? S_DONE : S_JUMP_Y;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_STEP: begin
            y_in     = mac_res;
            state_in = S_DONE;
         end
         S_JUMP_Y: begin
            if (skip_ff[0]) begin
               y_in = mac_res;
            end
            // no higher skip bits left: the squared map is never needed
            state_in = (skip_rest == '0) ? S_DONE : S_JUMP_ADD;
         end
         S_JUMP_ADD: begin
            padd_in  = mac_res;
            state_in = S_JUMP_MUL;
         end
         S_JUMP_MUL: begin
            pmul_in  = mac_res;
            skip_in  = skip_rest;
            state_in = S_JUMP_Y;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         y_ff     <= '0;
      end else begin
         state_ff <= state_in;
         y_ff     <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      pmul_ff <= pmul_in;
      padd_ff <= padd_in;
      skip_ff <= skip_in;
   end

   assign stat.done  = (state_ff == S_DONE);
   assign stat.state = y_ff;

`ifndef NO_ASSERTIONS
   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_jump_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_port.op == OP_JUMP && skip_new != '0 |=> state_ff == S_JUMP_Y)
      else $error("non-zero jump did not start the bit loop");

   a_skip_shift: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_JUMP_MUL |=> state_ff == S_JUMP_Y && skip_ff == $past(skip_rest))
      else $error("skip count not shifted after squaring");

   a_y_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_JUMP_ADD || state_ff == S_JUMP_MUL || state_ff == S_DONE
      |=> $stable(y_ff))
      else $error("state changed outside an update step");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !out_free |=> state_ff == S_DONE)
      else $error("result dropped while output register busy");
`endif

endmodule

/* design/lcg_with_jump_ahead_core.sv */
// BSD-style LCG (mod 2^31) with jump-ahead: top level with result register.
// Depends on lcgj_pkg, lcgj_if and lcgj_ctrl.
//
// Usage: each request transaction on req_port carries op and value. op
// OP_LOAD sets the state to value mod 2^31, OP_NEXT advances one step,
// OP_JUMP advances by the low SKIP_BITS bits of value; an unused op code
// leaves the state alone. Every request gives one response transaction on
// rsp_port whose rand_value is the state after the operation.
// From acceptance to rsp valid, a load, unused op or zero jump passes through
// S_DONE and the output register, a single step through S_STEP first. A jump
// walks the skip bits from the lowest up to the highest set bit: each uses
// the shared multiply-add once to apply the map (kept only if the bit is set)
// and, but for the highest, twice to square it. One request is in work at a time;
// the next one is taken once the previous result sits in the output register.
// Reset (synchronous, active high) clears the state to zero and empties the
// output register. If the receiver stalls, the result waits in the output
// register; one further request may complete and then waits in the sequencer.
module lcg_with_jump_ahead_core (
   input  logic       clock,
   input  logic       reset,
   lcgj_req_if.sink   req_port,
   lcgj_rsp_if.source rsp_port
);
   import lcgj_pkg::*;

   ctrl_stat_type      stat;
   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0] rsp_data_ff, rsp_data_in;

   lcgj_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .out_free (out_free),
      .stat     (stat)
   );

   assign out_free = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = stat.done;
         rsp_data_in  = stat.state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.rand_value = rsp_data_ff;

endmodule

/* tb/tb_lcg_with_jump_ahead_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lcg_with_jump_ahead_core: random load/next/jump traffic
// under four idle/stall phases, with responses checked against an in-bench generator model.
// Depends on lcgj_pkg, lcgj_if and the design files.
module tb_lcg_with_jump_ahead_core;
   import lcgj_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = OP_W'(3);
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int ITEMS_PHASE   = 175;
   localparam int DRAIN_CYCLES  = 100;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
   } lcg_cmd_type;

   logic clock;
   logic reset;

   lcgj_req_if req_if ();
   lcgj_rsp_if rsp_if ();

   lcg_with_jump_ahead_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   lcg_cmd_type        pending_cmds[$];
   logic [STATE_W-1:0] expected_states[$];
   logic [STATE_W-1:0] gen_state;
   int                 send_idle_pct;
   int                 recv_stall_pct;
   int                 mismatches;
   int                 cycle_count;

   // (m*y + k) mod 2^31
   function automatic logic [STATE_W-1:0] lcg_mac(input logic [STATE_W-1:0] m,
                                                  input logic [STATE_W-1:0] k,
                                                  input logic [STATE_W-1:0] y);
      logic [63:0] prod;
      prod = 64'(m) * 64'(y) + 64'(k);
      return prod[STATE_W-1:0];
   endfunction

   // square-and-multiply of the affine map over the skip bits
   function automatic logic [STATE_W-1:0] lcg_skip_ahead(input logic [STATE_W-1:0] y,
                                                         input logic [VALUE_W-1:0] value);
      logic [STATE_W-1:0] pm;
      logic [STATE_W-1:0] pk;
      logic [63:0]        skip;
      pm   = LCG_MUL;
      pk   = LCG_ADD;
      skip = 64'(value);
      for (int b = 0; b < SKIP_BITS && b < 64; b++) begin
         if (skip[b])
            y = lcg_mac(pm, pk, y);
         pk = lcg_mac(pm, pk, pk);
         pm = lcg_mac(pm, '0, pm);
      end
      return y;
   endfunction

   function automatic logic [STATE_W-1:0] next_gen_state(input logic [STATE_W-1:0] y,
                                                         input lcg_cmd_type cmd);
      case (cmd.op)
         OP_LOAD: return cmd.value[STATE_W-1:0];
         OP_NEXT: return lcg_mac(LCG_MUL, LCG_ADD, y);
         OP_JUMP: return lcg_skip_ahead(y, cmd.value);
         default: return y;
      endcase
   endfunction

   function automatic lcg_cmd_type random_cmd();
      lcg_cmd_type c;
      int          sel;
      int          nb;
      sel     = $urandom_range(99);
      c.value = $urandom;
      if (sel < 20)
         c.op = OP_LOAD;
      else if (sel < 55)
         c.op = OP_NEXT;
      else if (sel < 90) begin
         c.op = OP_JUMP;
         // keep most skips short, a few full width
         if ($urandom_range(9) < 6)
            nb = $urandom_range(0, 8);
         else
            nb = $urandom_range(0, VALUE_W);
         c.value = (nb == 0) ? '0 : c.value >> (VALUE_W - nb);
      end else
         c.op = OP_UNUSED;
      return c;
   endfunction

   task automatic push_cmd(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
      lcg_cmd_type c;
      c.op    = op;
      c.value = value;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.op      = '0;
      req_if.value   = '0;
      rsp_if.ready   = 1'b0;
      reset          = 1'b1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: predicts on each accepted request transaction
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gen_state    = '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            lcg_cmd_type acc;
            acc.op    = req_if.op;
            acc.value = req_if.value;
            gen_state = next_gen_state(gen_state, acc);
            expected_states.insert(expected_states.size(), gen_state);
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               lcg_cmd_type c;
               c = pending_cmds.pop_front();
               req_if.valid <= 1'b1;
               req_if.op    <= c.op;
               req_if.value <= c.value;
            end else
               req_if.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         mismatches   = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_states.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("unexpected response transaction: rand_value %h", rsp_if.rand_value);
               mismatches++;
            end else begin
               logic [STATE_W-1:0] exp_val;
               exp_val = expected_states.pop_front();
               if (rsp_if.rand_value !== exp_val) begin
                  if (mismatches < REPORT_LIMIT)
                     $display("rand_value mismatch: expected %h, got %h",
                              exp_val, rsp_if.rand_value);
                  mismatches++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset)
         cycle_count <= 0;
      else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      @(negedge reset);
      @(negedge clock);
      // directed: field extremes, every op, unused op, zero and wide jumps, wide seeds
      push_cmd(OP_NEXT, '0);
      push_cmd(OP_LOAD, 32'hFFFF_FFFF);
      push_cmd(OP_NEXT, 32'hFFFF_FFFF);
      push_cmd(OP_LOAD, 32'h8000_0000);
      push_cmd(OP_NEXT, '0);
      push_cmd(OP_LOAD, 32'h7FFF_FFFF);
      push_cmd(OP_UNUSED, 32'h1234_5678);
      push_cmd(OP_JUMP, '0);
      push_cmd(OP_JUMP, 32'd1);
      push_cmd(OP_JUMP, 32'd2);
      push_cmd(OP_JUMP, 32'd3);
      push_cmd(OP_JUMP, 32'h8000_0000);
      push_cmd(OP_JUMP, 32'hFFFF_FFFF);
      push_cmd(OP_LOAD, '0);
      push_cmd(OP_JUMP, 32'h0000_0100);
      push_cmd(OP_UNUSED, '0);
      push_cmd(OP_UNUSED, 32'hFFFF_FFFF);
      push_cmd(OP_LOAD, 32'd12345);
      push_cmd(OP_NEXT, '0);
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 65;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 65;
            end
            default: begin
               send_idle_pct  = 14;
               recv_stall_pct = 14;
            end
         endcase
         repeat (ITEMS_PHASE) pending_cmds.insert(pending_cmds.size(), random_cmd());
         while (pending_cmds.size() != 0 || req_if.valid || expected_states.size() != 0)
            @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_states.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* lcg_with_jump_ahead_core.f */
design/lcgj_pkg.sv
design/lcgj_if.sv
design/lcgj_mac.sv
design/lcgj_ctrl.sv
design/lcg_with_jump_ahead_core.sv
tb/tb_lcg_with_jump_ahead_core.sv
